[design/dpfc_pkg.sv]
// Package: shared widths, types and codes for the distinct prime factor counter.
`timescale 1ns / 1ps

package dpfc_pkg;

    // Width of the integer being factored
    localparam int VALUE_BITS  = 20;
    // Fixed width of the reported run start
    localparam int FIRST_BITS  = 20;
    localparam int WIDE_BITS   = (VALUE_BITS > FIRST_BITS) ? VALUE_BITS : FIRST_BITS;
    // Trial divisor: just past sqrt(2^VALUE_BITS)
    localparam int D_BITS      = (VALUE_BITS + 1) / 2 + 1;
    // Running square of the trial divisor
    localparam int SQ_BITS     = VALUE_BITS + 2;
    localparam int STEP_BITS   = $clog2(VALUE_BITS);
    localparam int COUNT_BITS  = 3;
    localparam int TARGET_BITS = 3;
    localparam int LENGTH_BITS = 4;
    localparam int RUN_BITS    = 4;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    // Register indexes (paddr[2])
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    localparam logic [TARGET_BITS-1:0] TARGET_RESET = TARGET_BITS'(4);
    localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(4);

    // Divider result bundle
    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quot;
        logic [VALUE_BITS-1:0] rem;
    } t_div_rsp;

endpackage

[design/dpfc_div.sv]
// Module: restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module dpfc_div
    import dpfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [D_BITS-1:0]     i_divisor,
    output t_div_rsp              o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_quot;
    logic [D_BITS-1:0]     r_divisor;

    logic [VALUE_BITS:0]   rem_shift;
    logic [VALUE_BITS:0]   div_ext;
    logic                  fits;

    // One restoring step: shift in next dividend bit, subtract if it fits
    assign rem_shift = {r_rem, r_quot[VALUE_BITS-1]};
    assign div_ext   = (VALUE_BITS+1)'(r_divisor);
    assign fits      = (rem_shift >= div_ext);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_BITS'(1);
                if (r_step == STEP_BITS'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quot    <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= VALUE_BITS'(rem_shift - div_ext);
            end else begin
                r_rem <= rem_shift[VALUE_BITS-1:0];
            end
            r_quot <= {r_quot[VALUE_BITS-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

[design/distinct_prime_factor_counter.sv]
// Top level: distinct prime factor counter with consecutive-run detector.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------------------
//  input    | i_in_valid / o_in_stall        | i_value
//  output   | o_out_valid / i_out_stall      | o_prime_count, o_run_done, o_run_first
//  config   | APB psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Each trial divisor costs one compare state plus a division in the shared divider,
// and each factor divided out costs one more division. o_in_stall is high from
// acceptance until the result is in the output register; that register lets a new
// transaction start while the last result waits under i_out_stall.
// Synchronous active-low reset clears the sequencer, run state, output valid
// and configuration registers.
`timescale 1ns / 1ps

module distinct_prime_factor_counter
    import dpfc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [VALUE_BITS-1:0]  i_value,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COUNT_BITS-1:0]  o_prime_count,
    output logic                   o_run_done,
    output logic [FIRST_BITS-1:0]  o_run_first,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_FINAL = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [TARGET_BITS-1:0]  r_target;
    logic [LENGTH_BITS-1:0]  r_length;
    logic [RUN_BITS-1:0]     r_run_counter;
    logic [VALUE_BITS-1:0]   r_prev;
    logic [VALUE_BITS-1:0]   r_value;
    logic [VALUE_BITS-1:0]   r_n;
    logic [D_BITS-1:0]       r_d;
    logic [SQ_BITS-1:0]      r_sq;
    logic [COUNT_BITS-1:0]   r_cnt;
    logic                    r_found;
    logic                    r_out_valid;
    logic [COUNT_BITS-1:0]   r_prime_count;
    logic                    r_run_done;
    logic [FIRST_BITS-1:0]   r_run_first;

    t_div_rsp                div_rsp;
    logic                    div_start;
    logic [VALUE_BITS-1:0]   div_dividend;
    logic                    in_accept;
    logic                    out_free;
    logic                    cfg_write;
    logic                    sq_le_n;
    logic                    div_exact;
    logic [COUNT_BITS-1:0]   cnt_inc;
    logic [COUNT_BITS-1:0]   n_final_cnt;
    logic [LENGTH_BITS-1:0]  run_len;
    logic                    follows;
    logic                    qualifies;
    logic [RUN_BITS-1:0]     n_run_counter;
    logic                    run_hit;
    logic [VALUE_BITS-1:0]   first_val;
    logic [WIDE_BITS-1:0]    first_wide;

    // Handshakes
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_write  = psel && penable && pwrite;
    assign pready     = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
            r_length <= LENGTH_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_TARGET: r_target <= pwdata[TARGET_BITS-1:0];
                REG_LENGTH: r_length <= pwdata[LENGTH_BITS-1:0];
                default:    r_target <= r_target;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TARGET: prdata = DATA_BITS'(r_target);
            REG_LENGTH: prdata = DATA_BITS'(r_length);
            default:    prdata = '0;
        endcase
    end

    // Shared divider
    assign sq_le_n      = (r_sq <= SQ_BITS'(r_n));
    assign div_exact    = div_rsp.done && (div_rsp.rem == '0);
    assign div_start    = ((r_state == S_CHECK) && sq_le_n)
                       || ((r_state == S_DIV) && div_exact);
    assign div_dividend = (r_state == S_DIV) ? div_rsp.quot : r_n;

    dpfc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_d),
        .o_rsp      (div_rsp)
    );

    // Saturating count of distinct factors
    assign cnt_inc     = (r_cnt == '1) ? r_cnt : r_cnt + COUNT_BITS'(1);
    assign n_final_cnt = (r_n > VALUE_BITS'(1)) ? cnt_inc : r_cnt;

    // Run tracking on the finished count
    assign run_len   = (r_length == '0) ? LENGTH_BITS'(1) : r_length;
    assign follows   = ((VALUE_BITS+1)'(r_prev) + (VALUE_BITS+1)'(1))
                       == (VALUE_BITS+1)'(r_value);
    assign qualifies = (n_final_cnt == r_target);

    always_comb begin
        if (!qualifies) begin
            n_run_counter = '0;
        end else if ((r_run_counter != '0) && follows) begin
            n_run_counter = r_run_counter + RUN_BITS'(1);
        end else begin
            n_run_counter = RUN_BITS'(1);
        end
    end

    assign run_hit    = (n_run_counter != '0) && (n_run_counter >= run_len);
    assign first_val  = r_value - VALUE_BITS'(run_len - LENGTH_BITS'(1));
    assign first_wide = WIDE_BITS'(first_val);

    // Sequencer and trial-division datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_run_counter <= '0;
            r_prev        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // output register fills from the final state, empties on acceptance
            if ((r_state == S_FINAL) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= sq_le_n ? S_DIV : S_FINAL;
                end
                S_DIV: begin
                    if (div_rsp.done && !div_exact) begin
                        r_state <= S_CHECK;
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        r_state       <= S_IDLE;
                        r_run_counter <= run_hit ? '0 : n_run_counter;
                        r_prev        <= r_value;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        // load a new value
        if (in_accept) begin
            r_value <= i_value;
            r_n     <= i_value;
            r_d     <= D_BITS'(2);
            r_sq    <= SQ_BITS'(4);
            r_cnt   <= '0;
            r_found <= 1'b0;
        end
        // divide out a factor, or move to the next candidate
        if ((r_state == S_DIV) && div_rsp.done) begin
            if (div_exact) begin
                r_n     <= div_rsp.quot;
                r_found <= 1'b1;
                if (!r_found) begin
                    r_cnt <= cnt_inc;
                end
            end else begin
                r_d     <= r_d + D_BITS'(1);
                r_sq    <= r_sq + SQ_BITS'({r_d, 1'b1});
                r_found <= 1'b0;
            end
        end
        // result register
        if ((r_state == S_FINAL) && out_free) begin
            r_prime_count <= n_final_cnt;
            r_run_done    <= run_hit;
            r_run_first   <= run_hit ? first_wide[FIRST_BITS-1:0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_prime_count = r_prime_count;
    assign o_run_done    = r_run_done;
    assign o_run_first   = r_run_first;

endmodule

[verif/tb_distinct_prime_factor_counter.sv]
// Testbench: distinct prime factor counter checked against a run-tracking predictor.
`timescale 1ns / 1ps

module tb_distinct_prime_factor_counter;
    import dpfc_pkg::*;

    localparam int          CLK_HALF    = 4;
    localparam int          RESET_LEN   = 9;
    localparam longint      CYCLE_LIMIT = 12_000_000;
    localparam int          TAIL_CYCLES = 64;
    localparam logic [ADDR_BITS-1:0] ADDR_TARGET = ADDR_BITS'({REG_TARGET, 2'b00});
    localparam logic [ADDR_BITS-1:0] ADDR_LENGTH = ADDR_BITS'({REG_LENGTH, 2'b00});
    localparam logic [VALUE_BITS-1:0] VALUE_MAX  = {VALUE_BITS{1'b1}};

    typedef struct packed {
        logic [COUNT_BITS-1:0] prime_count;
        logic                  run_done;
        logic [FIRST_BITS-1:0] run_first;
    } t_factor_result;

    // DUT connections
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    logic [VALUE_BITS-1:0] in_value    = '0;
    logic                  out_stall   = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [ADDR_BITS-1:0]  paddr       = '0;
    logic [DATA_BITS-1:0]  pwdata      = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [COUNT_BITS-1:0] o_prime_count;
    logic                  o_run_done;
    logic [FIRST_BITS-1:0] o_run_first;

    // Predictor state and register copies
    logic [TARGET_BITS-1:0] target_reg = TARGET_RESET;
    logic [LENGTH_BITS-1:0] length_reg = LENGTH_RESET;
    logic [RUN_BITS-1:0]    run_members = '0;
    logic [VALUE_BITS-1:0]  last_value  = '0;

    t_factor_result expected_results[$];
    int             errors      = 0;
    longint         cycle_count = 0;
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             hold_cycles   = 0;

    distinct_prime_factor_counter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_value       (in_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_prime_count (o_prime_count),
        .o_run_done    (o_run_done),
        .o_run_first   (o_run_first),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("distinct_prime_factor_counter: mismatch");
            $finish;
        end
    end

    // Trial division, each factor divided out completely
    function automatic logic [COUNT_BITS-1:0] count_distinct_primes(
        input logic [VALUE_BITS-1:0] v
    );
        longint unsigned n;
        longint unsigned d;
        int unsigned     hits;
        n    = v;
        d    = 2;
        hits = 0;
        if (n < 2) return '0;
        while (d * d <= n) begin
            if (n % d == 0) begin
                hits++;
                while (n % d == 0) n = n / d;
            end
            d++;
        end
        if (n > 1) hits++;
        return (hits > 7) ? COUNT_BITS'(7) : COUNT_BITS'(hits);
    endfunction

    // Expected result for one accepted value; advances the run tracker
    function automatic t_factor_result predict_result(input logic [VALUE_BITS-1:0] v);
        t_factor_result res;
        int unsigned    len;
        res.prime_count = count_distinct_primes(v);
        res.run_done    = 1'b0;
        res.run_first   = '0;
        len = (length_reg == 0) ? 1 : int'(length_reg);
        if (res.prime_count == target_reg) begin
            // no wrap: the max value is never followed by zero
            if (run_members != 0 && {1'b0, v} == {1'b0, last_value} + 1'b1)
                run_members = run_members + 1'b1;
            else
                run_members = RUN_BITS'(1);
        end else begin
            run_members = '0;
        end
        if (run_members != 0 && int'(run_members) >= len) begin
            res.run_done  = 1'b1;
            res.run_first = FIRST_BITS'(v - VALUE_BITS'(len - 1));
            run_members   = '0;
        end
        last_value = v;
        return res;
    endfunction

    // Output checker: compare each accepted transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_factor_result want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, %s=%0d done=%0d first=%0d",
                         $time, "actual count", o_prime_count, o_run_done, o_run_first);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_prime_count !== want.prime_count) begin
                    $display("%0t: prime_count expected %0d actual %0d",
                             $time, want.prime_count, o_prime_count);
                    errors++;
                end
                if (o_run_done !== want.run_done) begin
                    $display("%0t: run_done expected %0d actual %0d",
                             $time, want.run_done, o_run_done);
                    errors++;
                end
                if (o_run_first !== want.run_first) begin
                    $display("%0t: run_first expected %0d actual %0d",
                             $time, want.run_first, o_run_first);
                    errors++;
                end
            end
        end
    end

    // Receiver: long hold-off when requested, else random stalls
    always @(negedge i_clk) begin
        if (hold_cycles != 0) begin
            out_stall = 1'b1;
            hold_cycles--;
        end else begin
            out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one value and wait for acceptance; called and returns at a falling edge
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_value = v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_result(v));
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_TARGET) target_reg = data[TARGET_BITS-1:0];
        else if (addr == ADDR_LENGTH) length_reg = data[LENGTH_BITS-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Registers change only with the block idle
    task automatic set_config(input int target, input int len);
        drain_results();
        apb_write(ADDR_TARGET, DATA_BITS'(target));
        apb_write(ADDR_LENGTH, DATA_BITS'(len));
    endtask

    task automatic send_sequence(input logic [VALUE_BITS-1:0] base, input int count);
        for (int k = 0; k < count; k++) send_value(base + VALUE_BITS'(k));
    endtask

    // Known run starts for small targets, else a random small base
    function automatic logic [VALUE_BITS-1:0] pick_run_base(input int target);
        int sel;
        sel = $urandom_range(3);
        if ($urandom_range(1) == 0) begin
            case (target)
                1: return (sel[0]) ? VALUE_BITS'(2) : VALUE_BITS'(7);
                2: case (sel)
                       0: return VALUE_BITS'(14);
                       1: return VALUE_BITS'(20);
                       2: return VALUE_BITS'(33);
                       default: return VALUE_BITS'(141);
                   endcase
                3: return (sel[0]) ? VALUE_BITS'(644) : VALUE_BITS'(1308);
                default: ;
            endcase
        end
        return VALUE_BITS'($urandom_range(2, 3000));
    endfunction

    // Default registers: the four-member run of four-factor values
    task automatic test_reset_defaults();
        send_sequence(VALUE_BITS'(134043), 4);
    endtask

    task automatic test_field_extremes();
        send_value('0);
        send_value(VALUE_BITS'(1));
        send_value(VALUE_BITS'(2));
        send_value(VALUE_MAX);
        send_value(VALUE_BITS'(999983));   // largest prime below 10^6
        send_value(VALUE_BITS'(510510));   // seven distinct primes
        send_value(VALUE_BITS'(524288));   // top bit alone, single prime
        set_config(7, 15);
        send_value(VALUE_BITS'(510510));
    endtask

    task automatic test_degenerate_settings();
        // zero target lets zero and one qualify; zero length acts as one
        set_config(0, 0);
        send_value('0);
        send_value(VALUE_BITS'(1));
        // qualifying value that breaks the sequence starts a new run
        set_config(1, 8);
        send_sequence(VALUE_BITS'(2), 3);
        send_value(VALUE_BITS'(7));
    endtask

    task automatic test_short_runs();
        // completion resets the counter so runs never overlap
        set_config(2, 2);
        send_sequence(VALUE_BITS'(14), 3);
        send_sequence(VALUE_BITS'(20), 3);
        send_value(VALUE_BITS'(35));
    endtask

    task automatic test_random_runs(input int items, input int send_pct, input int rx_pct);
        int sent;
        int seqs;
        int target;
        int len;
        int count;
        int r;
        logic [VALUE_BITS-1:0] base;
        sent = 0;
        seqs = 0;
        drain_results();
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        while (sent < items) begin
            if (seqs % 4 == 0) begin
                r      = $urandom_range(9);
                target = (r < 6) ? 1 + (r % 3) : $urandom_range(0, 7);
                r      = $urandom_range(9);
                len    = (r < 6) ? $urandom_range(1, 4) :
                         (r < 8) ? $urandom_range(0, 15) : ((r == 8) ? 8 : 15);
                set_config(target, len);
            end
            seqs++;
            if ($urandom_range(9) < 8) begin
                // well-formed consecutive sequence, occasionally with a skip
                base  = pick_run_base(target) - VALUE_BITS'($urandom_range(0, 2));
                count = $urandom_range(1, 9);
                for (int k = 0; k < count; k++) begin
                    if ($urandom_range(9) == 0) base = base + 1'b1;
                    send_value(base + VALUE_BITS'(k));
                end
                sent += count;
            end else begin
                // noise: mostly small, some across the full range
                if ($urandom_range(9) < 7) send_value(VALUE_BITS'($urandom_range(0, 4095)));
                else send_value(VALUE_BITS'($urandom_range(0, (1 << VALUE_BITS) - 1)));
                sent++;
            end
        end
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure_fill();
        set_config(2, 3);
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge i_clk);
        hold_cycles = 3000;
        @(negedge i_clk);
        send_sequence(VALUE_BITS'(140), 16);
        drain_results();
    endtask

    initial begin
        repeat (RESET_LEN) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_degenerate_settings();
        test_short_runs();
        test_random_runs(12, 0, 0);
        test_random_runs(12, 49, 0);
        test_random_runs(12, 0, 49);
        test_random_runs(12, 22, 22);
        test_backpressure_fill();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("distinct_prime_factor_counter: match");
        end else begin
            $display("distinct_prime_factor_counter: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
design/dpfc_pkg.sv
design/dpfc_div.sv
design/distinct_prime_factor_counter.sv
verif/tb_distinct_prime_factor_counter.sv
